// ----- design/lswg_pkg.sv -----
// Shared types, register codes and reset constants of the line sensor width gauge.
package lswg_pkg;

	localparam int DEF_MAX_PIXELS = 2048;
	localparam int DEF_MAX_LAG    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int POS_W      = 11;
	localparam int DIA_W      = 27;
	localparam int DIV_W      = 36;

	localparam logic [10:0] RST_WINDOW_START = 11'd8;
	localparam logic [10:0] RST_WINDOW_END   = 11'd2039;
	localparam logic [4:0]  RST_EDGE_LAG     = 5'd4;
	localparam logic [15:0] RST_SCALE        = 16'd1000;
	localparam logic        RST_FILTER_EN    = 1'b1;
	localparam logic [7:0]  RST_FILTER_W     = 8'd3;

	localparam logic [7:0] PIX_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_START = 3'd0,
		REG_WINDOW_END   = 3'd1,
		REG_EDGE_LAG     = 3'd2,
		REG_SCALE        = 3'd3,
		REG_FILTER_EN    = 3'd4,
		REG_FILTER_W     = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MID,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} gauge_state_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_last;
	} sample_t;

	typedef struct packed {
		logic [DIA_W-1:0] diameter;
		logic [POS_W-1:0] edge_distance;
		logic [7:0]       threshold;
		logic [7:0]       frame_min;
		logic [7:0]       frame_max;
		logic             status;
	} result_t;

endpackage

// ----- design/line_sensor_width_gauge.sv -----
// Line sensor width gauge: edge tracking over a pixel stream and per-frame diameter result.
// Throughput: one pixel per cycle within a frame; the lag line memory is read as a pixel is taken.
// Result path: frame-end state, then output state; with the running average a multiply state and
// 36 restoring divide steps come between; input stalls until the result is loaded.
// Reset (arst_n low) loads register defaults and clears the lag-line valid bits and the frame
// tracking; unwritten lag entries read as zero, so no clearing pass is needed.
module line_sensor_width_gauge import lswg_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS,
	parameter int MAX_LAG    = DEF_MAX_LAG
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam int IDXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW   = (IDXW > POS_W) ? IDXW : POS_W;
	localparam int LAGW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int LW   = $clog2(MAX_LAG + 1);
	localparam int CMPW = ((LW > 5) ? LW : 5) + 1;
	localparam int AW2  = ((LAGW > LW) ? LAGW : LW) + 1;
	localparam int CNTW = $clog2(DIV_W);

	// configuration
	logic [10:0] win_start_q, win_end_q;
	logic [4:0]  edge_lag_q;
	logic [15:0] scale_q;
	logic        filter_en_q;
	logic [7:0]  filter_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= RST_WINDOW_START;
			win_end_q   <= RST_WINDOW_END;
			edge_lag_q  <= RST_EDGE_LAG;
			scale_q     <= RST_SCALE;
			filter_en_q <= RST_FILTER_EN;
			filter_w_q  <= RST_FILTER_W;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_START: win_start_q <= cfg_data[10:0];
				REG_WINDOW_END:   win_end_q   <= cfg_data[10:0];
				REG_EDGE_LAG:     edge_lag_q  <= cfg_data[4:0];
				REG_SCALE:        scale_q     <= cfg_data;
				REG_FILTER_EN:    filter_en_q <= cfg_data[0];
				REG_FILTER_W:     filter_w_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	gauge_state_t state_q, state_d;

	logic sample_acc;
	logic valid_s1, last_s1;
	logic clear_frame, out_load;

	assign sample_acc = sample_valid && !sample_stall;

	// lag line: circular memory, valid bits stand in for its zero reset
	logic [7:0]      lag_mem [MAX_LAG];
	logic [MAX_LAG-1:0] lag_vld_q;
	logic [LAGW-1:0] wptr_q;
	logic [LW-1:0]   lag_sat;
	logic [CMPW-1:0] lag_cmp;
	logic [AW2-1:0]  rd_wide;
	logic [LAGW-1:0] rd_addr;
	logic [7:0]      rd_data_s1;
	logic            rd_ok_s1;

	assign lag_cmp = CMPW'(edge_lag_q);
	assign lag_sat = (lag_cmp > CMPW'(MAX_LAG)) ? LW'(MAX_LAG) : LW'(lag_cmp);
	assign rd_wide = (AW2'(wptr_q) >= AW2'(lag_sat))
		? AW2'(wptr_q) - AW2'(lag_sat)
		: AW2'(wptr_q) + AW2'(MAX_LAG) - AW2'(lag_sat);
	assign rd_addr = rd_wide[LAGW-1:0];

	// read sees the entry before this request's write lands
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			lag_mem[wptr_q] <= sample.pixel;
			rd_data_s1      <= lag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_vld_q <= '0;
			wptr_q    <= '0;
			rd_ok_s1  <= 1'b0;
		end else if (sample_acc) begin
			lag_vld_q[wptr_q] <= 1'b1;
			rd_ok_s1          <= lag_vld_q[rd_addr];
			wptr_q <= (wptr_q == LAGW'(MAX_LAG - 1)) ? '0 : wptr_q + LAGW'(1);
		end
	end

	// pixel index and stage-one request
	logic [IDXW-1:0] pix_cnt_q, idx_s1;
	logic [7:0]      px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			valid_s1 <= sample_acc;
			if (sample_acc)
				last_s1 <= sample.frame_last;
			if (clear_frame)
				pix_cnt_q <= '0;
			else if (sample_acc)
				pix_cnt_q <= (pix_cnt_q == IDXW'(MAX_PIXELS - 1)) ? '0 : pix_cnt_q + IDXW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			px_s1  <= sample.pixel;
			idx_s1 <= pix_cnt_q;
		end
	end

	// frame tracking
	logic [7:0]       run_min_q, run_max_q, best_rise_q, best_fall_q;
	logic [POS_W-1:0] rise_idx_q, fall_idx_q;
	logic [CW-1:0]    idx_c;
	logic [7:0]       old_px;
	logic             in_win;

	assign idx_c  = CW'(idx_s1);
	assign in_win = (idx_c >= CW'(win_start_q)) && (idx_c <= CW'(win_end_q));
	assign old_px = (lag_sat == '0) ? px_s1 : (rd_ok_s1 ? rd_data_s1 : 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q   <= PIX_MAX;
			run_max_q   <= '0;
			best_rise_q <= '0;
			best_fall_q <= '0;
			rise_idx_q  <= '0;
			fall_idx_q  <= '0;
		end else if (clear_frame) begin
			run_min_q   <= PIX_MAX;
			run_max_q   <= '0;
			best_rise_q <= '0;
			best_fall_q <= '0;
		end else if (valid_s1 && in_win) begin
			if (px_s1 > run_max_q)
				run_max_q <= px_s1;
			if (px_s1 < run_min_q)
				run_min_q <= px_s1;
			if (px_s1 >= old_px) begin
				if (px_s1 - old_px > best_rise_q) begin
					best_rise_q <= px_s1 - old_px;
					rise_idx_q  <= idx_c[POS_W-1:0];
				end
			end else if (old_px - px_s1 > best_fall_q) begin
				best_fall_q <= old_px - px_s1;
				fall_idx_q  <= idx_c[POS_W-1:0];
			end
		end
	end

	// frame-end figures
	logic [7:0]       mid_c, mid_q, min_q, max_q, mean_q;
	logic [POS_W-1:0] dist_c, dist_q;
	logic [DIA_W-1:0] dia_c, dia_q, ldia_q;
	logic             err_c, err_q, direct_c;

	// unsigned midpoint of the running min and max, rounded toward the running min
	assign mid_c = (run_max_q >= run_min_q)
		? run_min_q + ((run_max_q - run_min_q) >> 1)
		: run_min_q - ((run_min_q - run_max_q) >> 1);
	assign dist_c = (rise_idx_q >= fall_idx_q) ? rise_idx_q - fall_idx_q
	                                           : fall_idx_q - rise_idx_q;
	assign dia_c    = DIA_W'(scale_q) * DIA_W'(dist_c);
	assign err_c    = (win_end_q <= win_start_q);
	assign direct_c = (mean_q == '0) || !filter_en_q;

	// weighted average: one multiply, then a two-lane restoring divider by W+1
	logic [DIV_W-1:0] num_t_q, num_d_q, num_t_nx, num_d_nx;
	logic [8:0]       rem_t_q, rem_d_q, rem_t_nx, rem_d_nx, sh_t, sh_d, divisor_q;
	logic [CNTW-1:0]  div_cnt_q;
	logic [15:0]      wmean_c;
	logic [34:0]      wdia_c;

	assign wmean_c = 16'(filter_w_q) * 16'(mean_q);
	assign wdia_c  = 35'(filter_w_q) * 35'(ldia_q);

	assign sh_t = {rem_t_q[7:0], num_t_q[DIV_W-1]};
	assign sh_d = {rem_d_q[7:0], num_d_q[DIV_W-1]};
	always_comb begin
		if (sh_t >= divisor_q) begin
			rem_t_nx = sh_t - divisor_q;
			num_t_nx = {num_t_q[DIV_W-2:0], 1'b1};
		end else begin
			rem_t_nx = sh_t;
			num_t_nx = {num_t_q[DIV_W-2:0], 1'b0};
		end
		if (sh_d >= divisor_q) begin
			rem_d_nx = sh_d - divisor_q;
			num_d_nx = {num_d_q[DIV_W-2:0], 1'b1};
		end else begin
			rem_d_nx = sh_d;
			num_d_nx = {num_d_q[DIV_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			ldia_q <= '0;
		end else if (state_q == ST_MID && !err_c && direct_c) begin
			mean_q <= mid_c;
			ldia_q <= dia_c;
		end else if (state_q == ST_DIV && div_cnt_q == '0) begin
			mean_q <= num_t_nx[7:0];
			ldia_q <= num_d_nx[DIA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MID: begin
				mid_q  <= mid_c;
				dist_q <= dist_c;
				dia_q  <= dia_c;
				min_q  <= run_min_q;
				max_q  <= run_max_q;
				err_q  <= err_c;
			end
			ST_MUL: begin
				num_t_q   <= DIV_W'(wmean_c) + DIV_W'(mid_q);
				num_d_q   <= DIV_W'(wdia_c) + DIV_W'(dia_q);
				rem_t_q   <= '0;
				rem_d_q   <= '0;
				divisor_q <= 9'(filter_w_q) + 9'd1;
				div_cnt_q <= CNTW'(DIV_W - 1);
			end
			ST_DIV: begin
				num_t_q   <= num_t_nx;
				num_d_q   <= num_d_nx;
				rem_t_q   <= rem_t_nx;
				rem_d_q   <= rem_d_nx;
				div_cnt_q <= div_cnt_q - CNTW'(1);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: if (valid_s1 && last_s1) state_d = ST_MID;
			ST_MID: state_d = (err_c || direct_c) ? ST_OUT : ST_MUL;
			ST_MUL: state_d = ST_DIV;
			ST_DIV: if (div_cnt_q == '0) state_d = ST_OUT;
			ST_OUT: if (!result_valid || !result_stall) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		clear_frame  = (state_q == ST_MID);
		out_load     = (state_q == ST_OUT) && (!result_valid || !result_stall);
		sample_stall = (state_q != ST_RUN) || (valid_s1 && last_s1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (out_load)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (err_q) begin
				result.diameter      <= '0;
				result.edge_distance <= '0;
				result.threshold     <= '0;
				result.frame_min     <= '0;
				result.frame_max     <= '0;
				result.status        <= 1'b1;
			end else begin
				result.diameter      <= ldia_q;
				result.edge_distance <= dist_q;
				result.threshold     <= mean_q;
				result.frame_min     <= min_q;
				result.frame_max     <= max_q;
				result.status        <= 1'b0;
			end
		end
	end

	a_last_to_mid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> state_q == ST_MID)
		else $error("frame end did not start the result sequence");

	a_clear_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MID |=> pix_cnt_q == '0 && run_max_q == '0 && best_rise_q == '0
			&& best_fall_q == '0 && run_min_q == PIX_MAX)
		else $error("frame tracking not cleared after frame end");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_cnt_q == '0 |=> state_q == ST_OUT)
		else $error("divider did not finish on its last step");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output state");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |-> result.diameter == '0 && result.threshold == '0
			&& result.edge_distance == '0 && result.frame_max == '0)
		else $error("window error result carries data");

endmodule
